// File: hw/rtl/hnms_pkg.sv
// ----------------------------------------------------------------------------
// hnms_pkg
// Shared types and constants for the height-map to normal-map block.
// ----------------------------------------------------------------------------
package hnms_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COORD_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = COORD_W + ROW_W;
    localparam int SIZE_W     = 9;
    localparam int MUL_W      = 24;
    localparam int PROD_W     = 2 * MUL_W;

    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [0:0] KIND_LOAD    = 1'b0;
    localparam logic [0:0] KIND_COMPUTE = 1'b1;

    localparam logic [15:0] Z_SQ = 16'd65025;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_WRITE,
        DP_START,
        DP_READ,
        DP_MUL_XX,
        DP_MUL_YY,
        DP_SUM_S,
        DP_MUL_MM,
        DP_MUL_RHS,
        DP_SAVE_RHS,
        DP_MUL_CC,
        DP_MUL_CS,
        DP_TEST,
        DP_FINAL,
        DP_EMIT
    } dp_op_t;

    typedef enum logic [1:0] {
        CAND_TOP,
        CAND_BIT,
        CAND_K
    } cand_sel_t;

    typedef struct packed {
        dp_op_t    op;
        cand_sel_t cand_sel;
        logic [2:0] nb;
        logic       issue;
        logic       acc;
        logic [1:0] ch;
        logic [2:0] bitpos;
    } dp_cmd_t;

    typedef struct packed {
        logic in_range;
        logic pass;
        logic out_free;
    } dp_sts_t;

endpackage

// File: hw/rtl/hnms_dp.sv
// ----------------------------------------------------------------------------
// hnms_dp
// Datapath: height store, neighbor gather, shared multiplier, channel search.
// ----------------------------------------------------------------------------
module hnms_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  hnms_pkg::dp_cmd_t       cmd,
    output hnms_pkg::dp_sts_t       sts,
    input  logic                    cfg_we,
    input  logic [0:0]              cfg_index,
    input  logic [8:0]              cfg_data,
    input  logic [7:0]              in_column,
    input  logic [7:0]              in_row,
    input  logic [7:0]              in_height,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [23:0]             out_data
);
    import hnms_pkg::*;

    logic [7:0]        mem [0:(1 << ADDR_W) - 1];
    logic [7:0]        rd_data_reg;
    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [SIZE_W-1:0] w_use, h_use;
    logic [7:0]        x_reg, y_reg, il_reg, ir_reg, it_reg, ib_reg;
    logic [7:0]        il_next, ir_next, it_next, ib_next;
    logic              in_range_reg;
    logic [2:0]        nb_d_reg;
    logic signed [11:0] gx_reg, gy_reg;
    logic signed [11:0] dgx, dgy;
    logic [7:0]        rx, ry;
    logic [PROD_W-1:0] prod_reg;
    logic [MUL_W-1:0]  s_reg;
    logic [PROD_W-1:0] rhs_reg;
    logic [7:0]        k_reg, cand;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [11:0]       mag;
    logic [11:0]       ax, ay;
    logic [PROD_W+1:0] prod4;
    logic              neg;
    logic [8:0]        qsum;
    logic [7:0]        q;
    logic [7:0]        nx_reg, ny_reg, nz_reg;
    logic [23:0]       out_data_reg;
    logic              out_valid_reg;

    always_comb
    begin
        w_use = (width_reg == '0) ? SIZE_W'(1) :
                (width_reg > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : width_reg;
        h_use = (height_reg == '0) ? SIZE_W'(1) :
                (height_reg > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_reg;
        il_next = (in_column == 8'd0) ? 8'(w_use - 9'd1) : in_column - 8'd1;
        ir_next = ({1'b0, in_column} + 9'd1 == w_use) ? 8'd0 : in_column + 8'd1;
        it_next = (in_row == 8'd0) ? 8'(h_use - 9'd1) : in_row - 8'd1;
        ib_next = ({1'b0, in_row} + 9'd1 == h_use) ? 8'd0 : in_row + 8'd1;
    end

    always_comb
    begin
        unique case (cmd.nb)
            3'd0: begin rx = il_reg; ry = it_reg; end
            3'd1: begin rx = il_reg; ry = y_reg;  end
            3'd2: begin rx = il_reg; ry = ib_reg; end
            3'd3: begin rx = x_reg;  ry = it_reg; end
            3'd4: begin rx = x_reg;  ry = ib_reg; end
            3'd5: begin rx = ir_reg; ry = it_reg; end
            3'd6: begin rx = ir_reg; ry = y_reg;  end
            default: begin rx = ir_reg; ry = ib_reg; end
        endcase
    end

    always_comb
    begin
        logic signed [11:0] v;
        v = signed'({4'd0, rd_data_reg});
        dgx = '0;
        dgy = '0;
        case (nb_d_reg)
            3'd0: begin dgx = v;        dgy = -v;       end
            3'd1: begin dgx = v <<< 1;                  end
            3'd2: begin dgx = v;        dgy = v;        end
            3'd3: begin                 dgy = -(v <<< 1); end
            3'd4: begin                 dgy = v <<< 1;  end
            3'd5: begin dgx = -v;       dgy = -v;       end
            3'd6: begin dgx = -(v <<< 1);               end
            default: begin dgx = -v;    dgy = v;        end
        endcase
    end

    always_comb
    begin
        ax = gx_reg[11] ? 12'(-gx_reg) : 12'(gx_reg);
        ay = gy_reg[11] ? 12'(-gy_reg) : 12'(gy_reg);
        unique case (cmd.ch)
            2'd0:    begin mag = 12'(ax << 1); neg = gx_reg[11]; end
            2'd1:    begin mag = 12'(ay << 1); neg = gy_reg[11]; end
            default: begin mag = 12'd255;      neg = 1'b0;       end
        endcase
        unique case (cmd.cand_sel)
            CAND_TOP: cand = 8'd128;
            CAND_BIT: cand = k_reg | (8'd1 << cmd.bitpos);
            default:  cand = k_reg;
        endcase
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            DP_MUL_XX:  begin mul_a = MUL_W'(ax << 1); mul_b = MUL_W'(ax << 1); end
            DP_MUL_YY:  begin mul_a = MUL_W'(ay << 1); mul_b = MUL_W'(ay << 1); end
            DP_MUL_MM:  begin mul_a = MUL_W'(mag);     mul_b = MUL_W'(mag);     end
            DP_MUL_RHS: begin mul_a = prod_reg[MUL_W-1:0]; mul_b = MUL_W'(Z_SQ); end
            DP_MUL_CC:  begin mul_a = MUL_W'(cand);    mul_b = MUL_W'(cand);    end
            DP_MUL_CS:  begin mul_a = prod_reg[MUL_W-1:0]; mul_b = s_reg;        end
            default:    begin mul_a = '0;              mul_b = '0;              end
        endcase
        prod4 = {prod_reg, 2'b00};
        qsum = neg ? (9'(k_reg) + ((prod4 != (PROD_W+2)'(rhs_reg)) ? 9'd1 : 9'd0))
                   : (9'(k_reg) + 9'd128);
        if (neg)
            q = (qsum > 9'd128) ? 8'd0 : 8'(9'd128 - qsum);
        else
            q = (qsum > 9'd255) ? 8'd255 : qsum[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_WRITE)
            mem[{in_row, in_column}] <= in_height;
        if (cmd.issue)
            rd_data_reg <= mem[{ry, rx}];
    end

    always_ff @(posedge clk)
    begin
        nb_d_reg <= cmd.nb;
        case (cmd.op)
            DP_START:
            begin
                x_reg  <= in_column;
                y_reg  <= in_row;
                il_reg <= il_next;
                ir_reg <= ir_next;
                it_reg <= it_next;
                ib_reg <= ib_next;
                in_range_reg <= ({1'b0, in_column} < w_use) && ({1'b0, in_row} < h_use);
                gx_reg <= '0;
                gy_reg <= '0;
            end
            DP_READ:
            begin
                if (cmd.acc)
                begin
                    gx_reg <= gx_reg + dgx;
                    gy_reg <= gy_reg + dgy;
                end
            end
            DP_MUL_XX, DP_MUL_MM, DP_MUL_RHS, DP_MUL_CC, DP_MUL_CS:
                prod_reg <= mul_a * mul_b;
            DP_MUL_YY:
            begin
                s_reg    <= prod_reg[MUL_W-1:0] + MUL_W'(Z_SQ);
                prod_reg <= mul_a * mul_b;
            end
            DP_SUM_S:
                s_reg <= s_reg + prod_reg[MUL_W-1:0];
            DP_SAVE_RHS:
            begin
                rhs_reg <= prod_reg;
                k_reg   <= 8'd0;
            end
            DP_TEST:
                if (sts.pass)
                    k_reg <= cand;
            DP_FINAL:
            begin
                unique case (cmd.ch)
                    2'd0:    nx_reg <= q;
                    2'd1:    ny_reg <= q;
                    default: nz_reg <= q;
                endcase
            end
            DP_EMIT:
                out_data_reg <= {nz_reg, ny_reg, nx_reg};
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= SIZE_W'(MAX_WIDTH);
            height_reg    <= SIZE_W'(MAX_HEIGHT);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == DP_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign sts.in_range = in_range_reg;
    assign sts.pass     = (prod4 <= (PROD_W+2)'(rhs_reg));
    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

endmodule

// File: hw/rtl/hnms_ctrl.sv
// ----------------------------------------------------------------------------
// hnms_ctrl
// Controller: sequences load, neighbor reads, magnitudes and channel searches.
// ----------------------------------------------------------------------------
module hnms_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [0:0]        in_kind,
    output logic              in_ready,
    output hnms_pkg::dp_cmd_t cmd,
    input  hnms_pkg::dp_sts_t sts
);
    import hnms_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_READ, ST_SQX, ST_SQY, ST_SUMS,
        ST_CH_M, ST_CH_R, ST_CH_H, ST_T_MUL1, ST_T_MUL2, ST_T_CMP,
        ST_F_MUL1, ST_F_MUL2, ST_F_CMP, ST_DONE
    } state_t;

    state_t     state_reg;
    logic [3:0] cnt_reg;
    logic [1:0] ch_reg;
    logic [2:0] bit_reg;
    logic       top_reg;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.op       = DP_IDLE;
        cmd.cand_sel = top_reg ? CAND_TOP : CAND_BIT;
        cmd.ch       = ch_reg;
        cmd.bitpos   = bit_reg;
        cmd.nb       = cnt_reg[2:0];
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    cmd.op = (in_kind == KIND_LOAD) ? DP_WRITE : DP_START;
            ST_READ:
            begin
                cmd.op    = DP_READ;
                cmd.issue = !cnt_reg[3];
                cmd.acc   = (cnt_reg != 4'd0);
            end
            ST_SQX:    cmd.op = DP_MUL_XX;
            ST_SQY:    cmd.op = DP_MUL_YY;
            ST_SUMS:   cmd.op = DP_SUM_S;
            ST_CH_M:   cmd.op = DP_MUL_MM;
            ST_CH_R:   cmd.op = DP_MUL_RHS;
            ST_CH_H:   cmd.op = DP_SAVE_RHS;
            ST_T_MUL1: cmd.op = DP_MUL_CC;
            ST_T_MUL2: cmd.op = DP_MUL_CS;
            ST_T_CMP:  cmd.op = DP_TEST;
            ST_F_MUL1: begin cmd.op = DP_MUL_CC; cmd.cand_sel = CAND_K; end
            ST_F_MUL2: cmd.op = DP_MUL_CS;
            ST_F_CMP:  cmd.op = DP_FINAL;
            ST_DONE:   if (sts.out_free) cmd.op = DP_EMIT;
            default:   cmd.op = DP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ch_reg    <= '0;
            bit_reg   <= '0;
            top_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    if (in_valid && in_kind == KIND_COMPUTE)
                        state_reg <= ST_CHECK;
                ST_CHECK:
                begin
                    cnt_reg   <= '0;
                    state_reg <= sts.in_range ? ST_READ : ST_IDLE;
                end
                ST_READ:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd8)
                        state_reg <= ST_SQX;
                end
                ST_SQX:  state_reg <= ST_SQY;
                ST_SQY:  state_reg <= ST_SUMS;
                ST_SUMS:
                begin
                    ch_reg    <= 2'd0;
                    state_reg <= ST_CH_M;
                end
                ST_CH_M: state_reg <= ST_CH_R;
                ST_CH_R: state_reg <= ST_CH_H;
                ST_CH_H:
                begin
                    top_reg   <= 1'b1;
                    state_reg <= ST_T_MUL1;
                end
                ST_T_MUL1: state_reg <= ST_T_MUL2;
                ST_T_MUL2: state_reg <= ST_T_CMP;
                ST_T_CMP:
                begin
                    top_reg <= 1'b0;
                    if (top_reg)
                    begin
                        bit_reg   <= 3'd6;
                        state_reg <= sts.pass ? ST_F_MUL1 : ST_T_MUL1;
                    end
                    else if (bit_reg == 3'd0)
                        state_reg <= ST_F_MUL1;
                    else
                    begin
                        bit_reg   <= bit_reg - 3'd1;
                        state_reg <= ST_T_MUL1;
                    end
                end
                ST_F_MUL1: state_reg <= ST_F_MUL2;
                ST_F_MUL2: state_reg <= ST_F_CMP;
                ST_F_CMP:
                begin
                    if (ch_reg == 2'd2)
                        state_reg <= ST_DONE;
                    else
                    begin
                        ch_reg    <= ch_reg + 2'd1;
                        state_reg <= ST_CH_M;
                    end
                end
                ST_DONE:
                    if (sts.out_free)
                        state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && cnt_reg == 4'd8) |=> state_reg == ST_SQX)
        else $error("read phase overran");
    a_skip_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && !sts.in_range) |=> state_reg == ST_IDLE)
        else $error("out of range item not dropped");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_EMIT) |-> sts.out_free)
        else $error("emit into full output");
    a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_F_CMP) |-> (ch_reg != 2'd3))
        else $error("bad channel");

endmodule

// File: hw/rtl/height_to_normal_map_sobel_top.sv
// ----------------------------------------------------------------------------
// height_to_normal_map_sobel_top
// Height map to RGB normal map with a wrap-around Sobel filter.
// ----------------------------------------------------------------------------
// Input stream: tuser is the kind (load or compute), tdata carries column,
// row and height. A load request writes one sample into the 256x256 store in
// the cycle it is accepted, and the input stays ready for the next request.
// A compute request gives one RGB result on the output stream, or nothing if
// the pixel lies outside the image size in use (then the input is ready again
// after the range check). An in-range compute request goes through the range
// check, single-port store reads for the eight neighbors, the squared length,
// then for each of the three channels a pass on a shared 24x24 multiplier
// (bound setup, an eight-step search, a rounding step), and the hand-over of
// the result. One request is worked on at a time.
// The result sits in an output register, so a stalled receiver holds up only
// the next in-range compute result; loads are taken until that request is
// accepted. Reset sets both size registers to 256; the store content is
// undefined until loaded.
// Configuration writes must be made only while no request is in flight; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module height_to_normal_map_sobel_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // column[7:0], row[15:8], height_value[23:16]
    input  logic [0:0]  s_axis_tuser,   // kind[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // normal_x[7:0], normal_y[15:8], normal_z[23:16]
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [8:0]  cfg_data
);
    import hnms_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    in_valid;

    assign in_valid = s_axis_tvalid && s_axis_tready;

    hnms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    hnms_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_column (s_axis_tdata[7:0]),
        .in_row    (s_axis_tdata[15:8]),
        .in_height (s_axis_tdata[23:16]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the height-map to normal-map Sobel block. Loads and
// compute requests go in on the input stream with random gaps. Each normal is
// predicted from a local copy of the height store and size registers, then
// checked field by field against the output stream under random stalls.
// ----------------------------------------------------------------------------
module testbench;

    import hnms_pkg::*;

    typedef struct packed {
        logic [7:0] nz;
        logic [7:0] ny;
        logic [7:0] nx;
    } normal_t;

    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE_TICKS = 150;
    localparam int ITEM_TARGET  = 1950;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [8:0]  cfg_data;

    logic [7:0]  heights [MAX_WIDTH*MAX_HEIGHT];
    bit          loaded  [MAX_WIDTH*MAX_HEIGHT];
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    normal_t     expected_normals[$];
    int          mismatches;
    int          requests_sent;
    int          idle_ticks;
    int          out_stall;
    bit          no_idle;

    height_to_normal_map_sobel_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_size(logic [8:0] v, int max_v);
        if (v < 1)
            return 1;
        if (v > max_v)
            return max_v;
        return int'(v);
    endfunction

    function automatic logic [7:0] channel_code(longint c, longint unsigned s);
        longint unsigned m;
        longint unsigned k;
        longint unsigned rhs;
        longint q;
        m = (c < 0) ? -c : c;
        rhs = 65025 * m * m;
        k = 0;
        while (k < 128 && 4 * (k + 1) * (k + 1) * s <= rhs)
            k++;
        if (c >= 0)
            q = k;
        else
            q = -longint'(k + ((4 * k * k * s != rhs) ? 1 : 0));
        q += 128;
        if (q < 0)
            q = 0;
        if (q > 255)
            q = 255;
        return q[7:0];
    endfunction

    function automatic longint hgt(int x, int y);
        return longint'(heights[y * MAX_WIDTH + x]);
    endfunction

    // Applies one accepted request to the local store and queues any normal.
    function automatic void predict_request(logic [0:0] kind, int x, int y, logic [7:0] hv);
        int w;
        int h;
        int il;
        int ir;
        int it;
        int ib;
        longint dx;
        longint dy;
        longint unsigned s;
        normal_t n;
        if (kind == KIND_LOAD)
        begin
            heights[y * MAX_WIDTH + x] = hv;
            loaded[y * MAX_WIDTH + x]  = 1'b1;
            return;
        end
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        if (x >= w || y >= h)
            return;
        il = (x == 0) ? w - 1 : x - 1;
        ir = (x + 1 == w) ? 0 : x + 1;
        it = (y == 0) ? h - 1 : y - 1;
        ib = (y + 1 == h) ? 0 : y + 1;
        dx = 2 * ((hgt(il, it) + 2 * hgt(il, y) + hgt(il, ib))
                - (hgt(ir, it) + 2 * hgt(ir, y) + hgt(ir, ib)));
        dy = 2 * ((hgt(il, ib) + 2 * hgt(x, ib) + hgt(ir, ib))
                - (hgt(il, it) + 2 * hgt(x, it) + hgt(ir, it)));
        s = dx * dx + dy * dy + 65025;
        n.nx = channel_code(dx, s);
        n.ny = channel_code(dy, s);
        n.nz = channel_code(255, s);
        expected_normals = {expected_normals, n};
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Valid is left high after acceptance; it drops only on a gap or a drain.
    task automatic send_request(logic [0:0] kind, int x, int y, logic [7:0] hv);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {hv, y[7:0], x[7:0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_request(kind, x, y, hv);
        requests_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_normals.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic set_size(logic [8:0] w, logic [8:0] h);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we    <= 1'b0;
        width_reg  = w;
        height_reg = h;
    endtask

    task automatic load_missing(int x, int y);
        int w;
        int h;
        int cols[3];
        int rows[3];
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        cols = '{(x == 0) ? w - 1 : x - 1, x, (x + 1 == w) ? 0 : x + 1};
        rows = '{(y == 0) ? h - 1 : y - 1, y, (y + 1 == h) ? 0 : y + 1};
        foreach (cols[i])
            foreach (rows[j])
                if (!loaded[rows[j] * MAX_WIDTH + cols[i]])
                    send_request(KIND_LOAD, cols[i], rows[j], 8'($urandom_range(0, 255)));
    endtask

    task automatic compute_at(int x, int y);
        load_missing(x, y);
        send_request(KIND_COMPUTE, x, y, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_directed();
        // steepest slopes at the far corners of the full image
        send_request(KIND_LOAD, 255, 255, 8'hFF);
        send_request(KIND_LOAD, 0, 255, 8'hFF);
        send_request(KIND_LOAD, 1, 255, 8'hFF);
        send_request(KIND_LOAD, 255, 0, 8'h00);
        send_request(KIND_LOAD, 1, 0, 8'h00);
        send_request(KIND_LOAD, 255, 1, 8'h00);
        send_request(KIND_LOAD, 0, 1, 8'h00);
        send_request(KIND_LOAD, 1, 1, 8'h00);
        compute_at(0, 0);
        compute_at(255, 255);
        compute_at(0, 255);
        // single pixel image: every neighbor is the pixel itself
        set_size(9'd1, 9'd1);
        compute_at(0, 0);
        send_request(KIND_COMPUTE, 1, 0, 8'h00);
        send_request(KIND_COMPUTE, 0, 1, 8'h00);
        // zero and oversized registers clamp
        set_size(9'd0, 9'd511);
        compute_at(0, 200);
        send_request(KIND_COMPUTE, 1, 3, 8'h00);
        set_size(9'd300, 9'd0);
        compute_at(255, 0);
        send_request(KIND_COMPUTE, 4, 1, 8'h00);
        set_size(9'd2, 9'd2);
        compute_at(1, 1);
        send_request(KIND_COMPUTE, 255, 0, 8'h00);
    endtask

    task automatic random_phase(int count);
        int w;
        int h;
        int sel;
        case ($urandom_range(0, 6))
            0: set_size(9'd256, 9'd256);
            1: set_size(9'($urandom_range(1, 4)), 9'($urandom_range(1, 4)));
            2: set_size(9'($urandom_range(2, 16)), 9'($urandom_range(2, 16)));
            3: set_size(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)));
            4: set_size(9'd256, 9'($urandom_range(1, 8)));
            5: set_size(9'($urandom_range(1, 8)), 9'd256);
            default: set_size(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
        endcase
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        for (int n = 0; n < count && requests_sent < ITEM_TARGET; n++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
                compute_at($urandom_range(0, w - 1), $urandom_range(0, h - 1));
            else if (sel == 7 && w < 256)
                send_request(KIND_COMPUTE, $urandom_range(w, 255), $urandom_range(0, 255),
                             8'($urandom_range(0, 255)));
            else if (sel == 7 && h < 256)
                send_request(KIND_COMPUTE, $urandom_range(0, 255), $urandom_range(h, 255),
                             8'($urandom_range(0, 255)));
            else
                send_request(KIND_LOAD, $urandom_range(0, 255), $urandom_range(0, 255),
                             8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random();
        int phase;
        phase = 0;
        while (requests_sent < ITEM_TARGET)
        begin
            no_idle = (phase % 4 == 1);
            random_phase($urandom_range(40, 160));
            phase++;
        end
        no_idle = 1'b0;
    endtask

    task automatic test_pause_until_empty();
        set_size(9'd8, 9'd8);
        repeat (6)
            compute_at($urandom_range(0, 7), $urandom_range(0, 7));
        drain();
        repeat (6)
            compute_at($urandom_range(0, 7), $urandom_range(0, 7));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            out_stall     <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_normals.size() == 0)
                    report_mismatch($sformatf("unexpected normal %h", m_axis_tdata));
                else
                begin
                    normal_t n;
                    n = expected_normals.pop_front();
                    if (m_axis_tdata[7:0] !== n.nx)
                        report_mismatch($sformatf("normal_x %h, want %h",
                                                  m_axis_tdata[7:0], n.nx));
                    if (m_axis_tdata[15:8] !== n.ny)
                        report_mismatch($sformatf("normal_y %h, want %h",
                                                  m_axis_tdata[15:8], n.ny));
                    if (m_axis_tdata[23:16] !== n.nz)
                        report_mismatch($sformatf("normal_z %h, want %h",
                                                  m_axis_tdata[23:16], n.nz));
                end
                out_stall <= no_idle ? 0 : $urandom_range(0, 8);
                m_axis_tready <= 1'b0;
            end
            else if (out_stall > 0)
            begin
                out_stall     <= out_stall - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_ticks <= 0;
        else if (idle_ticks >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_ticks <= idle_ticks + 1;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_LOAD;
        cfg_we        = 1'b0;
        cfg_index     = REG_IMAGE_WIDTH;
        cfg_data      = '0;
        width_reg     = 9'd256;
        height_reg    = 9'd256;
        mismatches    = 0;
        requests_sent = 0;
        no_idle       = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_pause_until_empty();
        test_random();

        drain();
        if (expected_normals.size() != 0)
            report_mismatch("normals still pending");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
